@@ rtl/hpool_pkg.sv @@
package hpool_pkg;

	// pool geometry
	localparam int SLOTS    = 64;
	localparam int GEN_BITS = 16;
	localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);

	// free slot search: groups of eight live bits
	localparam int GRP_SIZE = 8;
	localparam int NGRP     = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

	// request modes
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_ACCESS = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_STALE     = 2'd3;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [GEN_BITS-1:0] gen_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef struct packed {
		logic found;
		idx_t idx;
	} free_slot_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		gen_t data;
	} gen_wr_t;

endpackage

@@ rtl/hpool_req_if.sv @@
interface hpool_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  slot_index;
	logic [15:0] handle_generation;

	modport source (output valid, mode, slot_index, handle_generation, input ready);
	modport sink   (input valid, mode, slot_index, handle_generation, output ready);
endinterface

@@ rtl/hpool_rsp_if.sv @@
interface hpool_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_index;
	logic [15:0] out_generation;
	logic [6:0]  live_total;

	modport source (output valid, status, out_index, out_generation, live_total, input ready);
	modport sink   (input valid, status, out_index, out_generation, live_total, output ready);
endinterface

@@ rtl/hpool_free_find.sv @@
module hpool_free_find (
	input  logic [hpool_pkg::SLOTS-1:0] live,
	output hpool_pkg::free_slot_t       free_slot
);

	localparam int PAD_W = hpool_pkg::NGRP * hpool_pkg::GRP_SIZE;

	logic [PAD_W-1:0]                 free_pad;
	logic [hpool_pkg::NGRP-1:0]       grp_any;
	logic [hpool_pkg::GRP_W-1:0]      grp_sel;
	logic [hpool_pkg::GRP_SIZE-1:0]   grp_bits;
	logic [2:0]                       bit_sel;
	logic [hpool_pkg::GRP_W+2:0]      full_idx;

	// padding slots count as taken
	assign free_pad = PAD_W'(~live) & PAD_W'({hpool_pkg::SLOTS{1'b1}});

	always_comb begin
		for (int g = 0; g < hpool_pkg::NGRP; g++) begin
			grp_any[g] = |free_pad[g*hpool_pkg::GRP_SIZE +: hpool_pkg::GRP_SIZE];
		end
	end

	// lowest group with a free slot
	always_comb begin
		grp_sel = '0;
		for (int g = hpool_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				grp_sel = hpool_pkg::GRP_W'(g);
			end
		end
	end

	assign grp_bits = free_pad[grp_sel*hpool_pkg::GRP_SIZE +: hpool_pkg::GRP_SIZE];

	// lowest free slot inside that group
	always_comb begin
		bit_sel = '0;
		for (int b = hpool_pkg::GRP_SIZE - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_sel = 3'(b);
			end
		end
	end

	assign full_idx        = {grp_sel, bit_sel};
	assign free_slot.found = |grp_any;
	assign free_slot.idx   = full_idx[hpool_pkg::IDX_W-1:0];

endmodule

@@ rtl/hpool_gen_ram.sv @@
module hpool_gen_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  hpool_pkg::idx_t    rd_addr,
	input  hpool_pkg::gen_wr_t wr,
	output hpool_pkg::gen_t    rd_data
);

	hpool_pkg::gen_t             mem [hpool_pkg::SLOTS];
	logic [hpool_pkg::SLOTS-1:0] written_q;
	hpool_pkg::gen_t             rd_raw_q;
	logic                        rd_written_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// an entry never written reads as generation zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : '0;

endmodule

@@ rtl/generational_handle_pool.sv @@
// channel  role    payload                                      handshake
// req      sink    mode, slot_index, handle_generation          valid/ready
// rsp      source  status, out_index, out_generation, live_total valid/ready
//
// each item: the accept cycle reads the slot's generation from the
// generation ram, and the check stage that follows checks and writes back
// a new item is taken only once the previous one has left the check stage
// the result register lets the next item in while a result waits on rsp
// a stalled rsp holds the check stage, and with it req.ready, low
// reset clears live bits, live count and the ram's written marks at once:
// no clearing pass, the pool is usable as soon as reset is released
module generational_handle_pool (
	input logic         clk,
	input logic         arst_n,
	hpool_req_if.sink   req,
	hpool_rsp_if.source rsp
);

	// live bits and live count
	logic [hpool_pkg::SLOTS-1:0] live_q;
	hpool_pkg::cnt_t             count_q;

	// free slot search
	hpool_pkg::free_slot_t free_slot;

	// check stage
	logic             busy_s1;
	logic [1:0]       mode_s1;
	hpool_pkg::idx_t  idx_s1;
	logic             in_range_s1;
	logic             found_s1;
	logic [7:0]       req_idx_s1;
	logic [15:0]      req_gen_s1;

	// result register
	logic        rsp_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  out_index_q;
	logic [15:0] out_gen_q;
	logic [6:0]  live_total_q;

	logic               accept;
	logic               done;
	logic               is_create;
	hpool_pkg::idx_t    rd_addr;
	hpool_pkg::gen_t    slot_gen;
	hpool_pkg::gen_wr_t gen_wr;
	logic               slot_live;
	logic               gen_match;
	logic [1:0]         status_c;
	logic [7:0]         out_index_c;
	logic [15:0]        out_gen_c;
	logic               do_set;
	logic               do_clear;
	hpool_pkg::cnt_t    count_c;

	assign req.ready = !busy_s1;
	assign accept    = req.valid && req.ready;
	assign is_create = (req.mode == hpool_pkg::MODE_CREATE);

	hpool_free_find u_find (
		.live      (live_q),
		.free_slot (free_slot)
	);

	// create reads the lowest free slot, the others the handle's slot
	assign rd_addr = is_create ? free_slot.idx : req.slot_index[hpool_pkg::IDX_W-1:0];

	hpool_gen_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (gen_wr),
		.rd_data (slot_gen)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= req.mode;
			idx_s1      <= rd_addr;
			in_range_s1 <= ({1'b0, req.slot_index} < 9'(hpool_pkg::SLOTS));
			found_s1    <= free_slot.found;
			req_idx_s1  <= req.slot_index;
			req_gen_s1  <= req.handle_generation;
		end
	end

	// the check stage finishes once the result register is free or emptying
	assign done = busy_s1 && (!rsp_valid_q || rsp.ready);

	assign slot_live = in_range_s1 && live_q[idx_s1];
	assign gen_match = (32'(slot_gen) == 32'(req_gen_s1));

	always_comb begin
		status_c    = hpool_pkg::ST_OK;
		out_index_c = req_idx_s1;
		out_gen_c   = req_gen_s1;
		do_set      = 1'b0;
		do_clear    = 1'b0;
		case (mode_s1)
			hpool_pkg::MODE_CREATE: begin
				if (found_s1) begin
					out_index_c = 8'(idx_s1);
					out_gen_c   = 16'(slot_gen);
					do_set      = 1'b1;
				end else begin
					status_c    = hpool_pkg::ST_EXHAUSTED;
					out_index_c = '0;
					out_gen_c   = '0;
				end
			end
			hpool_pkg::MODE_REMOVE: begin
				if (!slot_live) begin
					status_c = hpool_pkg::ST_NOT_FOUND;
				end else if (!gen_match) begin
					status_c = hpool_pkg::ST_STALE;
				end else begin
					do_clear = 1'b1;
				end
			end
			default: begin
				// access check, and the unused mode code
				if (!slot_live) begin
					status_c = hpool_pkg::ST_NOT_FOUND;
				end else if (!gen_match) begin
					status_c = hpool_pkg::ST_STALE;
				end
			end
		endcase
	end

	always_comb begin
		count_c = count_q;
		if (do_set) begin
			count_c = count_q + 1'b1;
		end else if (do_clear && count_q != '0) begin
			count_c = count_q - 1'b1;
		end
	end

	// removal advances the generation, wrapping
	assign gen_wr.en   = done && do_clear;
	assign gen_wr.addr = idx_s1;
	assign gen_wr.data = slot_gen + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			live_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				if (do_set) begin
					live_q[idx_s1] <= 1'b1;
				end else if (do_clear) begin
					live_q[idx_s1] <= 1'b0;
				end
				count_q     <= count_c;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q     <= status_c;
			out_index_q  <= out_index_c;
			out_gen_q    <= out_gen_c;
			live_total_q <= 7'(count_c);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.out_index      = out_index_q;
	assign rsp.out_generation = out_gen_q;
	assign rsp.live_total     = live_total_q;

endmodule

@@ rtl/hpool_checker.sv @@
module hpool_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [6:0]  rsp_live_total
);

	// a waiting result keeps its status
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result changed while stalled");

	// one item in the check stage at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while another is in the check stage");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_live_total) <= hpool_pkg::SLOTS)
		else $error("live count beyond pool size");

	// exhaustion only with every slot live
	a_exhausted_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == hpool_pkg::ST_EXHAUSTED
			|-> 32'(rsp_live_total) == hpool_pkg::SLOTS)
		else $error("exhaustion reported with free slots");

endmodule

bind generational_handle_pool hpool_checker u_hpool_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_live_total (rsp.live_total)
);
